[src/dtq_pkg.sv]
package dtq_pkg;

  // Input transaction: an add or a tick
  typedef struct packed {
    logic        kind;
    logic [7:0]  job_id;
    logic [47:0] deadline;
    logic [47:0] now_time;
  } cmd_t;

  // Result transaction
  typedef struct packed {
    logic       due_valid;
    logic [7:0] due_job;
    logic [1:0] status;
    logic       last;
  } res_t;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Operation broadcast to every cell of the sorted chain
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

endpackage

[src/dtq_cell.sv]
module dtq_cell #(
  parameter int TIME_BITS = 48,
  parameter int SLOT_BITS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dtq_pkg::cell_op_t     op,
  // entry being inserted
  input  logic [TIME_BITS-1:0]  new_deadline,
  input  logic [SLOT_BITS-1:0]  new_slot,
  input  logic [7:0]            new_id,
  // left neighbor (closer to the head)
  input  logic                  left_gt,
  input  logic                  left_valid,
  input  logic [TIME_BITS-1:0]  left_deadline,
  input  logic [SLOT_BITS-1:0]  left_slot,
  input  logic [7:0]            left_id,
  // right neighbor (closer to the tail)
  input  logic                  right_valid,
  input  logic [TIME_BITS-1:0]  right_deadline,
  input  logic [SLOT_BITS-1:0]  right_slot,
  input  logic [7:0]            right_id,
  // own contents
  output logic                  valid,
  output logic [TIME_BITS-1:0]  deadline,
  output logic [SLOT_BITS-1:0]  slot,
  output logic [7:0]            id,
  output logic                  gt
);
  import dtq_pkg::*;

  // Cell sorts after the new entry; an empty cell sorts after everything.
  // The key is {deadline, slot} so equal deadlines fall back to slot order.
  assign gt = !valid || ({new_deadline, new_slot} < {deadline, slot});

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (op)
        CELL_INSERT: begin
          if (gt) begin
            valid <= left_gt ? left_valid : 1'b1;
          end
        end
        CELL_SHIFT: valid <= right_valid;
        default:    valid <= valid;
      endcase
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    case (op)
      CELL_INSERT: begin
        if (gt) begin
          if (left_gt) begin
            deadline <= left_deadline;
            slot     <= left_slot;
            id       <= left_id;
          end else begin
            deadline <= new_deadline;
            slot     <= new_slot;
            id       <= new_id;
          end
        end
      end
      CELL_SHIFT: begin
        deadline <= right_deadline;
        slot     <= right_slot;
        id       <= right_id;
      end
      default: begin
        deadline <= deadline;
      end
    endcase
  end

endmodule

[src/dtq_slot_alloc.sv]
module dtq_slot_alloc #(
  parameter int CAPACITY  = 16,
  parameter int SLOT_BITS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take_en,
  input  logic                 free_en,
  input  logic [SLOT_BITS-1:0] free_slot,
  output logic                 full,
  output logic [SLOT_BITS-1:0] free_idx,
  output logic [CAPACITY-1:0]  used
);

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_idx = SLOT_BITS'(i);
      end
    end
  end

  assign full = &used;

  // Slot occupancy; take and free never happen in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (take_en) begin
      used[free_idx] <= 1'b1;
    end else if (free_en) begin
      used[free_slot] <= 1'b0;
    end
  end

endmodule

[src/deadline_timer_queue_top.sv]
// Timer queue of up to CAPACITY jobs, kept sorted by {deadline, slot} in a
// chain of cells so the earliest job always sits in the head cell. An add
// gives a single result. A tick gives one result per released job, or a
// single result when nothing is due; released jobs come out one per
// cycle, at the rate the chain shifts toward the head. busy stays high until
// the last result of a transaction is registered, and results carry a
// one-cycle strobe that the receiver must take as it comes: there is no
// backpressure on the result side.
module deadline_timer_queue_top #(
  parameter int CAPACITY  = 16,
  parameter int TIME_BITS = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  dtq_pkg::cmd_t cmd,
  output logic          busy,
  output logic          strobe,
  output dtq_pkg::res_t result
);
  import dtq_pkg::*;

  localparam int SLOT_BITS = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_TICK
  } state_t;

  state_t state;
  cmd_t   cmd_q;

  logic [63:0]          dl_ext;
  logic [63:0]          now_ext;
  logic [TIME_BITS-1:0] new_deadline;
  logic [TIME_BITS-1:0] now_q;

  logic                 full;
  logic [SLOT_BITS-1:0] free_idx;
  logic [CAPACITY-1:0]  used;
  logic                 take_en;
  logic                 free_en;

  cell_op_t op;

  logic                 c_valid    [CAPACITY];
  logic [TIME_BITS-1:0] c_deadline [CAPACITY];
  logic [SLOT_BITS-1:0] c_slot     [CAPACITY];
  logic [7:0]           c_id       [CAPACITY];
  logic                 c_gt       [CAPACITY];
  logic [CAPACITY-1:0]  valid_vec;

  logic head_due;
  logic next_due;

  assign busy = (state != ST_IDLE);

  // Mask times to TIME_BITS
  assign dl_ext       = 64'(cmd_q.deadline);
  assign now_ext      = 64'(cmd_q.now_time);
  assign new_deadline = dl_ext[TIME_BITS-1:0];
  assign now_q        = now_ext[TIME_BITS-1:0];

  assign head_due = c_valid[0] && (c_deadline[0] <= now_q);
  assign next_due = c_valid[1] && (c_deadline[1] <= now_q);

  // Chain control
  always_comb begin
    op      = CELL_HOLD;
    take_en = 1'b0;
    free_en = 1'b0;
    case (state)
      ST_ADD: begin
        if (!full) begin
          op      = CELL_INSERT;
          take_en = 1'b1;
        end
      end
      ST_TICK: begin
        if (head_due) begin
          op      = CELL_SHIFT;
          free_en = 1'b1;
        end
      end
      default: begin
        op = CELL_HOLD;
      end
    endcase
  end

  dtq_slot_alloc #(
    .CAPACITY  (CAPACITY),
    .SLOT_BITS (SLOT_BITS)
  ) u_alloc (
    .clk       (clk),
    .rst       (rst),
    .take_en   (take_en),
    .free_en   (free_en),
    .free_slot (c_slot[0]),
    .full      (full),
    .free_idx  (free_idx),
    .used      (used)
  );

  // Sorted chain, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 l_gt;
    logic                 l_valid;
    logic [TIME_BITS-1:0] l_deadline;
    logic [SLOT_BITS-1:0] l_slot;
    logic [7:0]           l_id;
    logic                 r_valid;
    logic [TIME_BITS-1:0] r_deadline;
    logic [SLOT_BITS-1:0] r_slot;
    logic [7:0]           r_id;

    if (i == 0) begin : g_head
      assign l_gt       = 1'b0;
      assign l_valid    = 1'b0;
      assign l_deadline = '0;
      assign l_slot     = '0;
      assign l_id       = '0;
    end else begin : g_left
      assign l_gt       = c_gt[i-1];
      assign l_valid    = c_valid[i-1];
      assign l_deadline = c_deadline[i-1];
      assign l_slot     = c_slot[i-1];
      assign l_id       = c_id[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_valid    = 1'b0;
      assign r_deadline = '0;
      assign r_slot     = '0;
      assign r_id       = '0;
    end else begin : g_right
      assign r_valid    = c_valid[i+1];
      assign r_deadline = c_deadline[i+1];
      assign r_slot     = c_slot[i+1];
      assign r_id       = c_id[i+1];
    end

    dtq_cell #(
      .TIME_BITS (TIME_BITS),
      .SLOT_BITS (SLOT_BITS)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .op             (op),
      .new_deadline   (new_deadline),
      .new_slot       (free_idx),
      .new_id         (cmd_q.job_id),
      .left_gt        (l_gt),
      .left_valid     (l_valid),
      .left_deadline  (l_deadline),
      .left_slot      (l_slot),
      .left_id        (l_id),
      .right_valid    (r_valid),
      .right_deadline (r_deadline),
      .right_slot     (r_slot),
      .right_id       (r_id),
      .valid          (c_valid[i]),
      .deadline       (c_deadline[i]),
      .slot           (c_slot[i]),
      .id             (c_id[i]),
      .gt             (c_gt[i])
    );

    assign valid_vec[i] = c_valid[i];
  end

  // Sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            state <= (cmd.kind == KIND_TICK) ? ST_TICK : ST_ADD;
          end
        end
        ST_ADD: begin
          strobe           <= 1'b1;
          result.due_valid <= 1'b0;
          result.due_job   <= '0;
          result.status    <= full ? STAT_FULL : STAT_OK;
          result.last      <= 1'b1;
          state            <= ST_IDLE;
        end
        ST_TICK: begin
          strobe <= 1'b1;
          if (head_due) begin
            result.due_valid <= 1'b1;
            result.due_job   <= c_id[0];
            result.status    <= STAT_OK;
            result.last      <= !next_due;
            if (!next_due) begin
              state <= ST_IDLE;
            end
          end else begin
            result.due_valid <= 1'b0;
            result.due_job   <= '0;
            result.status    <= c_valid[0] ? STAT_OK : STAT_EMPTY;
            result.last      <= 1'b1;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Occupied cells stay packed toward the head: cell 1 holds a job only if cell 0 does
  a_packed: assert property (@(posedge clk) disable iff (rst)
    c_valid[1] |-> c_valid[0])
    else $error("chain has a hole behind the head cell");

  // Slot bitmap and chain agree on how many jobs are held
  a_count: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == $countones(valid_vec))
    else $error("slot bitmap and chain occupancy disagree");

  // A released job always reports ok status
  a_due_ok: assert property (@(posedge clk) disable iff (rst)
    strobe && result.due_valid |-> result.status == STAT_OK)
    else $error("released job carries a non-ok status");

  // A result that is not the last keeps the block busy
  a_more: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> busy)
    else $error("transaction ended without a last result");

  // Leaving a transaction coincides with its last result
  a_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> strobe && result.last)
    else $error("busy dropped without a last result");

endmodule

[tb/dtq_release_board_pkg.sv]
`timescale 1ns / 1ps

package dtq_release_board_pkg;
  import dtq_pkg::*;

  localparam int SLOTS = 16;

  // Mirror of the timer queue plus the list of results still owed by the DUT
  class timer_release_board;
    logic [47:0] slot_deadline [SLOTS];
    logic [7:0]  slot_job [SLOTS];
    bit          slot_used [SLOTS];
    res_t        awaited [$];
    int unsigned faults;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i]     = 1'b0;
        slot_deadline[i] = '0;
        slot_job[i]      = '0;
      end
      faults = 0;
    endfunction

    // Earliest due slot at time now; equal deadlines go to the lowest slot
    function int earliest_due(logic [47:0] now);
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && slot_deadline[i] <= now) begin
          if (best < 0 || slot_deadline[i] < slot_deadline[best]) best = i;
        end
      end
      return best;
    endfunction

    // Accepted transaction: update the mirror and queue the results it owes
    function void note_command(cmd_t c);
      res_t r;
      int   best;
      int   next;
      bit   placed;
      bit   any_left;
      r = '0;
      if (c.kind == KIND_ADD) begin
        placed = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!placed && !slot_used[i]) begin
            slot_used[i]     = 1'b1;
            slot_job[i]      = c.job_id;
            slot_deadline[i] = c.deadline;
            placed           = 1'b1;
          end
        end
        r.status = placed ? STAT_OK : STAT_FULL;
        r.last   = 1'b1;
        awaited.push_back(r);
      end else begin
        best = earliest_due(c.now_time);
        if (best < 0) begin
          any_left = 1'b0;
          foreach (slot_used[i]) if (slot_used[i]) any_left = 1'b1;
          r.status = any_left ? STAT_OK : STAT_EMPTY;
          r.last   = 1'b1;
          awaited.push_back(r);
        end
        // release due jobs one by one; the last one is flagged
        while (best >= 0) begin
          slot_used[best] = 1'b0;
          next        = earliest_due(c.now_time);
          r.due_valid = 1'b1;
          r.due_job   = slot_job[best];
          r.status    = STAT_OK;
          r.last      = (next < 0);
          awaited.push_back(r);
          best = next;
        end
      end
    endfunction

    // Compare one strobed result against the oldest expectation
    function void check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result valid=%0d job=%0d status=%0d last=%0d",
                 $time, got.due_valid, got.due_job, got.status, got.last);
        faults++;
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        $display("%0t: result mismatch: expected valid=%0d job=%0d status=%0d last=%0d, got valid=%0d job=%0d status=%0d last=%0d",
                 $time, want.due_valid, want.due_job, want.status, want.last,
                 got.due_valid, got.due_job, got.status, got.last);
        faults++;
      end
    endfunction
  endclass

endpackage

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import dtq_pkg::*;
  import dtq_release_board_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [47:0] TIME_MAX    = '1;

  logic clk = 1'b0;
  logic rst;
  logic start;
  cmd_t cmd;
  logic busy;
  logic strobe;
  res_t result;

  timer_release_board board;
  int unsigned        cycle_count = 0;
  bit                 idle_on = 1'b1;

  deadline_timer_queue_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always #5 clk = ~clk;

  // Run time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Monitor: check strobed results, record accepted transactions
  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (strobe === 1'b1) board.check_result(result);
      if (start && !busy) board.note_command(cmd);
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] wide;
    wide = {$urandom(), $urandom()};
    return wide[47:0];
  endfunction

  // Present one transaction and hold it until the DUT takes it
  task automatic send(cmd_t c);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 29) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic add_job(logic [7:0] id, logic [47:0] dl);
    cmd_t c;
    c.kind     = KIND_ADD;
    c.job_id   = id;
    c.deadline = dl;
    c.now_time = rand48();
    send(c);
  endtask

  task automatic tick(logic [47:0] now);
    cmd_t c;
    c.kind     = KIND_TICK;
    c.job_id   = 8'($urandom_range(0, 255));
    c.deadline = rand48();
    c.now_time = now;
    send(c);
  endtask

  // Stop sending until every owed result has come out
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (board.awaited.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  initial begin
    logic [47:0] clock_base;
    int          pick;
    cmd_t        c;

    board = new();
    rst   <= 1'b1;
    start <= 1'b0;
    cmd   <= '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty tick, extreme fields, nothing-due tick, full, ties
    tick('0);
    add_job(8'd255, TIME_MAX);
    add_job(8'd0, '0);
    tick('0);
    tick(TIME_MAX - 48'd1);
    for (int k = 1; k <= 15; k++) add_job(8'(k), 48'(100 + k % 3));
    add_job(8'd200, 48'd5);
    tick(TIME_MAX);
    tick(TIME_MAX);
    drain();

    // Random: mostly adds near a moving time base and ticks that advance it
    clock_base = {16'h0000, $urandom()};
    for (int n = 0; n < 64; n++) begin
      idle_on = !(n >= 40 && n < 80);
      if (n == 60) drain();
      // burst of adds to push the queue to full
      if (n % 40 == 20) begin
        for (int b = 0; b < 18; b++)
          add_job(8'($urandom_range(0, 255)), clock_base + 48'($urandom_range(0, 60)));
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        c.kind     = 1'($urandom_range(0, 1));
        c.job_id   = 8'($urandom_range(0, 255));
        c.deadline = rand48();
        c.now_time = rand48();
        send(c);
      end else if (pick < 58) begin
        add_job(8'($urandom_range(0, 255)), clock_base + 48'($urandom_range(0, 40)));
      end else begin
        clock_base = clock_base + 48'($urandom_range(0, 25));
        tick(clock_base);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (board.faults == 0 && board.awaited.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
src/dtq_pkg.sv
src/dtq_cell.sv
src/dtq_slot_alloc.sv
src/deadline_timer_queue_top.sv
tb/dtq_release_board_pkg.sv
tb/tb.sv
